/* rtl/core/lobm_pkg.sv */
`default_nettype none
package lobm_pkg;

  localparam int LVL_W = 6;

  typedef enum logic [2:0] {
    CMD_ADD   = 3'd0,
    CMD_AMEND = 3'd1,
    CMD_CANCEL = 3'd2,
    CMD_QUERY = 3'd3,
    CMD_LEVEL = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    RK_FILL  = 3'd0,
    RK_ACK   = 3'd1,
    RK_QUERY = 3'd2,
    RK_LEVEL = 3'd3,
    RK_ERROR = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    ER_NONE    = 3'd0,
    ER_DUP_ID  = 3'd1,
    ER_PRICE   = 3'd2,
    ER_QTY     = 3'd3,
    ER_UNKNOWN = 3'd4,
    ER_BELOW   = 3'd5,
    ER_NO_ROOM = 3'd6
  } err_t;

  typedef enum logic [2:0] {
    FL_EMPTY     = 3'd0,
    FL_OPEN_BUY  = 3'd1,
    FL_OPEN_SELL = 3'd2,
    FL_FILL_BUY  = 3'd3,
    FL_FILL_SELL = 3'd4,
    FL_CANC_BUY  = 3'd5,
    FL_CANC_SELL = 3'd6,
    FL_VOID      = 3'd7
  } flag_t;

  localparam logic [2:0] FL_STEP_FILL   = 3'd2;
  localparam logic [2:0] FL_STEP_CANCEL = 3'd4;

endpackage
`default_nettype wire

/* rtl/core/limit_order_book_matcher.sv */
`default_nettype none
// Each command runs one or more scans of the entry memory, one entry per cycle, set by
// the single read port of the memory.
// Amend, cancel, unknown or closed order query: one scan. Open order query: two scans.
// Add: one id scan, then if accepted one best-price scan per fill and one to finish.
// Level query: level_index + 2 scans. One command at a time; reset clears the fill count.
module limit_order_book_matcher #(
  parameter int MAX_ORDERS = 64,
  parameter int ID_BITS    = 16,
  parameter int PRICE_BITS = 20,
  parameter int QTY_BITS   = 24
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   in_valid,
  output logic                                        in_stall,
  input  wire logic [2:0]                             command,
  input  wire logic [ID_BITS-1:0]                     order_id,
  input  wire logic                                   side,
  input  wire logic [PRICE_BITS-1:0]                  price_ticks,
  input  wire logic [QTY_BITS-1:0]                    quantity,
  input  wire logic [lobm_pkg::LVL_W-1:0]             level_index,
  output logic                                        out_valid,
  input  wire logic                                   out_stall,
  output logic [2:0]                                  result_kind,
  output logic [2:0]                                  error_code,
  output logic [PRICE_BITS-1:0]                       price_value,
  output logic [QTY_BITS+$clog2(MAX_ORDERS)-1:0]      quantity_value,
  output logic [QTY_BITS-1:0]                         filled_amount,
  output logic                                        order_side,
  output logic [1:0]                                  order_status,
  output logic signed [$clog2(MAX_ORDERS):0]          queue_position,
  output logic                                        last
);
  import lobm_pkg::*;

  localparam int AW    = $clog2(MAX_ORDERS);
  localparam int SUM_W = QTY_BITS + AW;
  localparam logic [AW-1:0] LAST_IDX = AW'(MAX_ORDERS - 1);

  typedef struct packed {
    logic [ID_BITS-1:0]    id;
    logic [PRICE_BITS-1:0] price;
    logic [QTY_BITS-1:0]   total;
    logic [QTY_BITS-1:0]   filled;
    logic [31:0]           stamp;
    logic [2:0]            flags;
  } entry_t;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_POST, S_WAIT} state_t;
  typedef enum logic [2:0] {M_FIND, M_CROSS, M_LEVEL, M_SUM, M_QPOS} mode_t;

  state_t state;
  mode_t  mode;

  logic [2:0]            cmd;
  logic [ID_BITS-1:0]    id_r;
  logic                  side_r;
  logic [PRICE_BITS-1:0] price_r;
  logic [QTY_BITS-1:0]   qty_r;
  logic [LVL_W-1:0]      level_r;

  logic [AW:0]           fill;
  logic [31:0]           ctr;

  logic [AW-1:0] idx, pidx;
  logic          issuing, pv, plast, vq;

  logic          found, slot_found, bfound, lfound, have_prev, cont;
  logic [AW-1:0] fidx, slot, bidx;
  entry_t        fent, bent;
  logic [PRICE_BITS-1:0] cur, prev;
  logic [SUM_W-1:0]      sum;
  logic [AW-1:0]         cnt;
  logic [LVL_W-1:0]      k;
  logic [QTY_BITS-1:0]   filled;

  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  entry_t           wr_data;
  logic [$bits(entry_t)-1:0] rdata;
  entry_t           d;

  lobm_ram #(.WIDTH($bits(entry_t)), .DEPTH(MAX_ORDERS)) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (idx),
    .rdata (rdata)
  );

  logic dopen, dside, fopen, cross_cand, cross_better, lvl_cand, lvl_take;
  logic [QTY_BITS-1:0] rem, lv, fq;
  logic [2:0] fm1;

  always_comb begin
    d     = entry_t'(rdata);
    dopen = vq && (d.flags == FL_OPEN_BUY || d.flags == FL_OPEN_SELL);
    dside = ~d.flags[0];
    fopen = fent.flags == FL_OPEN_BUY || fent.flags == FL_OPEN_SELL;
    fm1   = fent.flags - 3'd1;
    cross_cand = dopen && (dside != side_r) &&
                 (side_r ? d.price >= price_r : d.price <= price_r);
    if (!bfound) begin
      cross_better = 1'b1;
    end else if (d.price != bent.price) begin
      cross_better = side_r ? d.price > bent.price : d.price < bent.price;
    end else begin
      cross_better = d.stamp < bent.stamp;
    end
    lvl_cand = dopen && (dside == side_r) &&
               (!have_prev || (side_r ? d.price > prev : d.price < prev));
    lvl_take = !lfound || (side_r ? d.price < cur : d.price > cur);
    rem = qty_r - filled;
    lv  = bent.total - bent.filled;
    fq  = (rem < lv) ? rem : lv;
  end

  assign in_stall = rst || (state != S_IDLE);

  always_ff @(posedge clk) begin
    wr_en <= 1'b0;
    if (rst) begin
      state     <= S_IDLE;
      fill      <= '0;
      ctr       <= '0;
      out_valid <= 1'b0;
      issuing   <= 1'b0;
      pv        <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            cmd        <= command;
            id_r       <= order_id;
            side_r     <= side;
            price_r    <= price_ticks;
            qty_r      <= quantity;
            level_r    <= level_index;
            found      <= 1'b0;
            slot_found <= 1'b0;
            have_prev  <= 1'b0;
            k          <= '0;
            filled     <= '0;
            lfound     <= 1'b0;
            mode       <= (command == CMD_LEVEL) ? M_LEVEL : M_FIND;
            idx        <= '0;
            issuing    <= 1'b1;
            state      <= S_SCAN;
          end
        end
        S_SCAN: begin
          pv    <= issuing;
          pidx  <= idx;
          plast <= (idx == LAST_IDX);
          vq    <= ({1'b0, idx} < fill);
          if (issuing) begin
            if (idx == LAST_IDX) begin
              issuing <= 1'b0;
            end else begin
              idx <= idx + AW'(1);
            end
          end
          if (pv) begin
            case (mode)
              M_FIND: begin
                if (vq && d.id == id_r && !found) begin
                  found <= 1'b1;
                  fidx  <= pidx;
                  fent  <= d;
                end
                if (!vq && !slot_found) begin
                  slot_found <= 1'b1;
                  slot       <= pidx;
                end
              end
              M_CROSS: begin
                if (cross_cand && cross_better) begin
                  bfound <= 1'b1;
                  bidx   <= pidx;
                  bent   <= d;
                end
              end
              M_LEVEL: begin
                if (lvl_cand && lvl_take) begin
                  lfound <= 1'b1;
                  cur    <= d.price;
                end
              end
              M_SUM: begin
                if (dopen && dside == side_r && d.price == cur) begin
                  sum <= sum + SUM_W'(d.total - d.filled);
                end
              end
              M_QPOS: begin
                if (pidx != fidx && dopen && dside == ~fent.flags[0] &&
                    d.price == fent.price && d.stamp < fent.stamp) begin
                  cnt <= cnt + AW'(1);
                end
              end
              default: ;
            endcase
            if (plast) begin
              state <= S_POST;
            end
          end
        end
        S_POST: begin
          result_kind    <= RK_ACK;
          error_code     <= ER_NONE;
          price_value    <= '0;
          quantity_value <= '0;
          filled_amount  <= '0;
          order_side     <= 1'b0;
          order_status   <= '0;
          queue_position <= '0;
          last           <= 1'b1;
          out_valid      <= 1'b1;
          cont           <= 1'b0;
          state          <= S_WAIT;
          case (mode)
            M_FIND: begin
              case (cmd)
                CMD_ADD: begin
                  if (found) begin
                    result_kind <= RK_ERROR;
                    error_code  <= ER_DUP_ID;
                  end else if (price_r == '0) begin
                    result_kind <= RK_ERROR;
                    error_code  <= ER_PRICE;
                  end else if (qty_r == '0) begin
                    result_kind <= RK_ERROR;
                    error_code  <= ER_QTY;
                  end else if (!slot_found) begin
                    result_kind <= RK_ERROR;
                    error_code  <= ER_NO_ROOM;
                  end else begin
                    out_valid <= 1'b0;
                    mode      <= M_CROSS;
                    bfound    <= 1'b0;
                    idx       <= '0;
                    issuing   <= 1'b1;
                    state     <= S_SCAN;
                  end
                end
                CMD_AMEND: begin
                  wr_addr <= fidx;
                  wr_data <= fent;
                  if (qty_r == '0) begin
                    result_kind <= RK_ERROR;
                    error_code  <= ER_QTY;
                  end else if (!found || !fopen) begin
                    result_kind <= RK_ERROR;
                    error_code  <= ER_UNKNOWN;
                  end else if (qty_r > fent.total) begin
                    wr_data.total <= qty_r;
                    wr_data.stamp <= ctr;
                    wr_en         <= 1'b1;
                    ctr           <= ctr + 32'd1;
                  end else if (qty_r < fent.total) begin
                    if (qty_r <= fent.filled) begin
                      result_kind <= RK_ERROR;
                      error_code  <= ER_BELOW;
                    end else begin
                      wr_data.total <= qty_r;
                      wr_en         <= 1'b1;
                    end
                  end
                end
                CMD_CANCEL: begin
                  if (!found || !fopen) begin
                    result_kind <= RK_ERROR;
                    error_code  <= ER_UNKNOWN;
                  end else begin
                    wr_addr       <= fidx;
                    wr_data       <= fent;
                    wr_data.flags <= fent.flags + FL_STEP_CANCEL;
                    wr_en         <= 1'b1;
                  end
                end
                CMD_QUERY: begin
                  if (!found) begin
                    result_kind <= RK_ERROR;
                    error_code  <= ER_UNKNOWN;
                  end else if (fopen) begin
                    out_valid <= 1'b0;
                    mode      <= M_QPOS;
                    cnt       <= '0;
                    idx       <= '0;
                    issuing   <= 1'b1;
                    state     <= S_SCAN;
                  end else begin
                    result_kind    <= RK_QUERY;
                    price_value    <= fent.price;
                    quantity_value <= SUM_W'(fent.total);
                    filled_amount  <= fent.filled;
                    order_side     <= ~fent.flags[0];
                    order_status   <= fm1[2:1];
                    queue_position <= '1;
                  end
                end
                default: ;
              endcase
            end
            M_CROSS: begin
              if (filled < qty_r && bfound) begin
                result_kind    <= RK_FILL;
                price_value    <= bent.price;
                quantity_value <= SUM_W'(fq);
                last           <= 1'b0;
                cont           <= 1'b1;
                filled         <= filled + fq;
                wr_addr        <= bidx;
                wr_data        <= bent;
                wr_data.filled <= bent.filled + fq;
                if (bent.filled + fq >= bent.total) begin
                  wr_data.flags <= bent.flags + FL_STEP_FILL;
                end
                wr_en <= 1'b1;
              end else begin
                wr_addr        <= slot;
                wr_data.id     <= id_r;
                wr_data.price  <= price_r;
                wr_data.total  <= qty_r;
                wr_data.filled <= filled;
                wr_data.stamp  <= ctr;
                if (filled >= qty_r) begin
                  wr_data.flags <= side_r ? FL_FILL_SELL : FL_FILL_BUY;
                end else begin
                  wr_data.flags <= side_r ? FL_OPEN_SELL : FL_OPEN_BUY;
                end
                wr_en <= 1'b1;
                fill  <= fill + (AW+1)'(1);
                ctr   <= ctr + 32'd1;
              end
            end
            M_LEVEL: begin
              if (!lfound) begin
                result_kind <= RK_ERROR;
                error_code  <= ER_NO_ROOM;
              end else begin
                out_valid <= 1'b0;
                prev      <= cur;
                have_prev <= 1'b1;
                lfound    <= 1'b0;
                idx       <= '0;
                issuing   <= 1'b1;
                state     <= S_SCAN;
                if (k == level_r) begin
                  mode <= M_SUM;
                  sum  <= '0;
                end else begin
                  k <= k + LVL_W'(1);
                end
              end
            end
            M_SUM: begin
              result_kind    <= RK_LEVEL;
              price_value    <= cur;
              quantity_value <= sum;
              order_side     <= side_r;
            end
            M_QPOS: begin
              result_kind    <= RK_QUERY;
              price_value    <= fent.price;
              quantity_value <= SUM_W'(fent.total);
              filled_amount  <= fent.filled;
              order_side     <= ~fent.flags[0];
              order_status   <= fm1[2:1];
              queue_position <= {1'b0, cnt};
            end
            default: ;
          endcase
        end
        S_WAIT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            if (cont) begin
              mode    <= M_CROSS;
              bfound  <= 1'b0;
              idx     <= '0;
              issuing <= 1'b1;
              state   <= S_SCAN;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_out_only_wait: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> state == S_WAIT)
    else $error("result word held outside wait state");

  a_no_write_in_scan: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> !issuing)
    else $error("entry write during a scan");

  a_scan_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && pv && plast) |=> state == S_POST)
    else $error("scan did not close");

  a_accept_scan: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == S_SCAN && issuing))
    else $error("accepted word did not start a scan");

endmodule
`default_nettype wire

/* rtl/core/lobm_ram.sv */
`default_nettype none
module lobm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire
